[src/dcc_pkg.sv]
// shared constants, register indexes and sideband type of the depth code converter
// used by every module of the block; no dependencies
package dcc_pkg;

  localparam logic [31:0] LEVEL_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] LEVEL_ODD     = 32'h8000_0000;

  // studio-range expansion, floor(x*1.164) as (x*LUMA_RECIP) >> 16
  localparam logic [7:0]  LUMA_LO       = 8'd16;
  localparam logic [7:0]  LUMA_HI       = 8'hEB;
  localparam logic [7:0]  LUMA_TOP      = 8'hFF;
  localparam logic [16:0] LUMA_RECIP    = 17'd76284;

  // ramp index boundaries
  localparam logic [7:0]  ZERO_IDX      = 8'd9;
  localparam logic [7:0]  NEAR_IDX      = 8'd17;
  localparam logic [7:0]  FAR_IDX       = 8'd224;
  localparam logic [7:0]  TOP_IDX       = 8'd240;

  // step = (far-near)/207 as a reciprocal multiply with one correction
  localparam logic [7:0]  RAMP_DIV      = 8'd207;
  localparam logic [31:0] RAMP_RECIP    = 32'd2655825187;
  localparam int          RAMP_SHIFT    = 39;
  localparam int          STEP_W        = 64 - RAMP_SHIFT;

  localparam logic [23:0] FULL24        = 24'd16777215;
  localparam logic [23:0] FULL16        = 24'd65535;

  localparam int          NUM_W         = 88;
  localparam int          DEN_W         = 64;
  localparam int          QBITS         = 33;
  localparam int          CMP_W         = DEN_W + QBITS;

  localparam logic [2:0]  REG_NEAR_LEVEL  = 3'd0;
  localparam logic [2:0]  REG_FAR_LEVEL   = 3'd1;
  localparam logic [2:0]  REG_NEAR_PLANE  = 3'd2;
  localparam logic [2:0]  REG_FAR_PLANE   = 3'd3;
  localparam logic [2:0]  REG_LUMA_EXPAND = 3'd4;
  localparam logic [2:0]  REG_DIRECT_MODE = 3'd5;
  localparam logic [2:0]  REG_DEPTH_16BIT = 3'd6;

  typedef struct packed {
    logic [31:0] dir_val;
    logic        direct;
    logic        d16;
    logic        bad;
    logic        zero;
  } side_t;

endpackage

[src/dcc_level.sv]
// code linearization and piecewise level mapping, four register stages
// depends on dcc_pkg
module dcc_level import dcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [7:0]  in_code,
  input  logic [31:0] near_level,
  input  logic [31:0] far_level,
  input  logic        luma_expand,
  output logic        lv_valid,
  output logic [31:0] lv_level
);

  logic [31:0] n_lvl, f_lvl;
  logic [7:0]  code_off, lin_nxt;
  logic [24:0] lin_prod;

  logic              v1_r, v2_r, v3_r, v4_r;
  logic [7:0]        lin1_r, lin2_r, lin3_r;
  logic [31:0]       diff1_r, diff2_r;
  logic [63:0]       prod2_r;
  logic [STEP_W-1:0] step3_r;
  logic [31:0]       level4_r;

  logic [STEP_W-1:0] q0;
  logic [32:0]       q0_mul, rem3;
  logic [STEP_W-1:0] step_nxt;
  logic [7:0]        lin_off;
  logic [32:0]       ramp_full;
  logic [31:0]       level_nxt;

  assign n_lvl = (near_level == LEVEL_ODD) ? LEVEL_MAX : near_level;
  assign f_lvl = (far_level == LEVEL_ODD) ? LEVEL_MAX : far_level;

  always_comb begin
    code_off = in_code - LUMA_LO;
    lin_prod = 25'(code_off) * 25'(LUMA_RECIP);
    if (!luma_expand) begin
      lin_nxt = in_code;
    end else if (in_code < LUMA_LO) begin
      lin_nxt = 8'd0;
    end else if (in_code > LUMA_HI) begin
      lin_nxt = LUMA_TOP;
    end else begin
      lin_nxt = lin_prod[23:16];
    end
  end

  // estimate is at most one short of the true quotient
  always_comb begin
    q0       = prod2_r[63:RAMP_SHIFT];
    q0_mul   = 33'(q0) * 33'(RAMP_DIV);
    rem3     = 33'(diff2_r) - q0_mul;
    step_nxt = q0 + STEP_W'(rem3 >= 33'(RAMP_DIV));
  end

  always_comb begin
    lin_off   = lin3_r - NEAR_IDX;
    ramp_full = 33'(lin_off) * 33'(step3_r);
    if (lin3_r < ZERO_IDX) begin
      level_nxt = 32'd0;
    end else if (lin3_r < NEAR_IDX) begin
      level_nxt = n_lvl;
    end else if (lin3_r < FAR_IDX) begin
      level_nxt = n_lvl + ramp_full[31:0];
    end else if (lin3_r < TOP_IDX) begin
      level_nxt = f_lvl;
    end else begin
      level_nxt = LEVEL_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin1_r   <= lin_nxt;
      diff1_r  <= f_lvl - n_lvl;
      lin2_r   <= lin1_r;
      diff2_r  <= diff1_r;
      prod2_r  <= 64'(diff1_r) * 64'(RAMP_RECIP);
      lin3_r   <= lin2_r;
      step3_r  <= step_nxt;
      level4_r <= level_nxt;
    end
  end

  assign lv_valid = v4_r;
  assign lv_level = level4_r;

endmodule

[src/dcc_persp.sv]
// direct-mode value and perspective numerator/denominator, four register stages
// depends on dcc_pkg
module dcc_persp import dcc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             lv_valid,
  input  logic [31:0]      lv_level,
  input  logic [31:0]      near_plane,
  input  logic [31:0]      far_plane,
  input  logic             direct_mode,
  input  logic             depth_16bit,
  output logic             pv_valid,
  output logic [NUM_W-1:0] pv_num,
  output logic [DEN_W-1:0] pv_den,
  output side_t            pv_side
);

  logic        v1_r, v2_r, v3_r, v4_r;
  side_t       side1_r, side2_r, side3_r, side4_r;
  logic [31:0] z1_r;
  logic [63:0] a1_r, b1_r;
  logic [32:0] absdd1_r;
  logic        negd1_r;
  logic [63:0] mag2_r, den2_r, den3_r;
  logic        neg2_r;
  logic [55:0] p0_3_r, p1_3_r;
  logic [NUM_W-1:0] num4_r;
  logic [DEN_W-1:0] den4_r;

  logic [31:0]        z;
  logic signed [32:0] f_s, z_s;
  logic signed [65:0] a_full;
  logic [63:0]        nx, b_nxt;
  logic [32:0]        dd, absdd;
  side_t              side_nxt, side3_nxt;
  logic               a_ge;
  logic [63:0]        mag_nxt;
  logic [64:0]        den_full;
  logic [23:0]        scale;

  always_comb begin
    z      = (lv_level == 32'd0) ? 32'd1 : lv_level;
    f_s    = {far_plane[31], far_plane};
    z_s    = {1'b0, z};
    a_full = f_s * z_s;
    // near * (2^31-1) without a multiplier
    nx     = {{32{near_plane[31]}}, near_plane};
    b_nxt  = (nx << 31) - nx;
    dd     = {far_plane[31], far_plane} - {near_plane[31], near_plane};
    absdd  = dd[32] ? (33'd0 - dd) : dd;
    side_nxt.direct  = direct_mode;
    side_nxt.d16     = depth_16bit;
    side_nxt.bad     = !direct_mode && (near_plane == far_plane);
    side_nxt.zero    = 1'b0;
    side_nxt.dir_val = depth_16bit ? {16'd0, lv_level[30:15]} : {lv_level[30:7], 8'd0};
  end

  always_comb begin
    a_ge     = $signed(a1_r) >= $signed(b1_r);
    mag_nxt  = a_ge ? (a1_r - b1_r) : (b1_r - a1_r);
    den_full = 65'(absdd1_r) * 65'(z1_r);
  end

  always_comb begin
    scale     = side2_r.d16 ? FULL16 : FULL24;
    side3_nxt = side2_r;
    // negative or zero result
    side3_nxt.zero = (mag2_r == 64'd0) || neg2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= lv_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r  <= side_nxt;
      z1_r     <= z;
      a1_r     <= a_full[63:0];
      b1_r     <= b_nxt;
      absdd1_r <= absdd;
      negd1_r  <= dd[32];

      side2_r  <= side1_r;
      mag2_r   <= mag_nxt;
      neg2_r   <= (!a_ge) ^ negd1_r;
      den2_r   <= den_full[63:0];

      side3_r  <= side3_nxt;
      p0_3_r   <= 56'(mag2_r[31:0]) * 56'(scale);
      p1_3_r   <= 56'(mag2_r[63:32]) * 56'(scale);
      den3_r   <= den2_r;

      side4_r  <= side3_r;
      num4_r   <= NUM_W'(p0_3_r) + (NUM_W'(p1_3_r) << 32);
      den4_r   <= den3_r;
    end
  end

  assign pv_valid = v4_r;
  assign pv_num   = num4_r;
  assign pv_den   = den4_r;
  assign pv_side  = side4_r;

endmodule

[src/dcc_div.sv]
// pipelined restoring divider, overflow check then one quotient bit per stage
// depends on dcc_pkg
module dcc_div import dcc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             pv_valid,
  input  logic [NUM_W-1:0] pv_num,
  input  logic [DEN_W-1:0] pv_den,
  input  side_t            pv_side,
  output logic             dv_valid,
  output logic [QBITS-1:0] dv_quot,
  output logic             dv_sat,
  output side_t            dv_side
);

  logic             v_r    [0:QBITS];
  logic [NUM_W-1:0] rem_r  [0:QBITS];
  logic [DEN_W-1:0] den_r  [0:QBITS];
  logic [QBITS-1:0] quot_r [0:QBITS];
  logic             sat_r  [0:QBITS];
  side_t            side_r [0:QBITS];

  logic sat_nxt;

  // quotient would not fit in QBITS bits
  assign sat_nxt = CMP_W'(pv_num) >= (CMP_W'(pv_den) << QBITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= pv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= pv_num;
      den_r[0]  <= pv_den;
      quot_r[0] <= '0;
      sat_r[0]  <= sat_nxt;
      side_r[0] <= pv_side;
    end
  end

  for (genvar g = 0; g < QBITS; g++) begin : g_stage
    localparam int K = QBITS - 1 - g;
    logic [CMP_W-1:0] trial;
    logic [CMP_W-1:0] rem_ext;
    logic             ge;
    logic [QBITS-1:0] quot_nxt;

    always_comb begin
      trial    = CMP_W'(den_r[g]) << K;
      rem_ext  = CMP_W'(rem_r[g]);
      ge       = rem_ext >= trial;
      quot_nxt = quot_r[g];
      quot_nxt[K] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g+1] <= 1'b0;
      end else if (en) begin
        v_r[g+1] <= v_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g+1]  <= ge ? NUM_W'(rem_ext - trial) : rem_r[g];
        den_r[g+1]  <= den_r[g];
        quot_r[g+1] <= quot_nxt;
        sat_r[g+1]  <= sat_r[g];
        side_r[g+1] <= side_r[g];
      end
    end
  end

  assign dv_valid = v_r[QBITS];
  assign dv_quot  = quot_r[QBITS];
  assign dv_sat   = sat_r[QBITS];
  assign dv_side  = side_r[QBITS];

endmodule

[src/zmovie_depth_code_convert_unit.sv]
// an accepted item passes through dcc_level, dcc_persp, dcc_div and then the output register
// throughput: one item per clock; the whole pipeline holds while a result waits
// the depth is set by the 34-stage divider of the perspective path
// reset (synchronous, rst_n low) clears all valid bits and loads register defaults
// depends on dcc_pkg, dcc_level, dcc_persp and dcc_div
module zmovie_depth_code_convert_unit import dcc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] depth_code
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] depth_value
  output logic        out_tuser,  // [0] clip_invalid
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [31:0] near_level_r, far_level_r, near_plane_r, far_plane_r;
  logic        luma_expand_r, direct_mode_r, depth_16bit_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  logic             en;
  logic             lv_valid;
  logic [31:0]      lv_level;
  logic             pv_valid;
  logic [NUM_W-1:0] pv_num;
  logic [DEN_W-1:0] pv_den;
  side_t            pv_side;
  logic             dv_valid;
  logic [QBITS-1:0] dv_quot;
  logic             dv_sat;
  side_t            dv_side;

  logic        out_valid_r;
  logic [31:0] out_data_r, out_data_nxt;
  logic        out_user_r, out_user_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_level_r  <= 32'd0;
      far_level_r   <= LEVEL_MAX;
      near_plane_r  <= 32'd0;
      far_plane_r   <= 32'd0;
      luma_expand_r <= 1'b0;
      direct_mode_r <= 1'b0;
      depth_16bit_r <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_NEAR_LEVEL:  near_level_r  <= cfg_pwdata;
        REG_FAR_LEVEL:   far_level_r   <= cfg_pwdata;
        REG_NEAR_PLANE:  near_plane_r  <= cfg_pwdata;
        REG_FAR_PLANE:   far_plane_r   <= cfg_pwdata;
        REG_LUMA_EXPAND: luma_expand_r <= cfg_pwdata[0];
        REG_DIRECT_MODE: direct_mode_r <= cfg_pwdata[0];
        REG_DEPTH_16BIT: depth_16bit_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_NEAR_LEVEL:  cfg_prdata = near_level_r;
      REG_FAR_LEVEL:   cfg_prdata = far_level_r;
      REG_NEAR_PLANE:  cfg_prdata = near_plane_r;
      REG_FAR_PLANE:   cfg_prdata = far_plane_r;
      REG_LUMA_EXPAND: cfg_prdata = {31'd0, luma_expand_r};
      REG_DIRECT_MODE: cfg_prdata = {31'd0, direct_mode_r};
      REG_DEPTH_16BIT: cfg_prdata = {31'd0, depth_16bit_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // pipeline moves whenever the output register is free or being drained
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  dcc_level u_level (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_tvalid),
    .in_code     (in_tdata),
    .near_level  (near_level_r),
    .far_level   (far_level_r),
    .luma_expand (luma_expand_r),
    .lv_valid    (lv_valid),
    .lv_level    (lv_level)
  );

  dcc_persp u_persp (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .lv_valid    (lv_valid),
    .lv_level    (lv_level),
    .near_plane  (near_plane_r),
    .far_plane   (far_plane_r),
    .direct_mode (direct_mode_r),
    .depth_16bit (depth_16bit_r),
    .pv_valid    (pv_valid),
    .pv_num      (pv_num),
    .pv_den      (pv_den),
    .pv_side     (pv_side)
  );

  dcc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .pv_valid (pv_valid),
    .pv_num   (pv_num),
    .pv_den   (pv_den),
    .pv_side  (pv_side),
    .dv_valid (dv_valid),
    .dv_quot  (dv_quot),
    .dv_sat   (dv_sat),
    .dv_side  (dv_side)
  );

  always_comb begin
    out_user_nxt = 1'b0;
    if (dv_side.direct) begin
      out_data_nxt = dv_side.dir_val;
    end else if (dv_side.bad) begin
      out_data_nxt = 32'd0;
      out_user_nxt = 1'b1;
    end else if (dv_side.zero) begin
      out_data_nxt = 32'd0;
    end else if (dv_side.d16) begin
      out_data_nxt = (dv_sat || (dv_quot[QBITS-1:16] != '0)) ? 32'h0000_FFFF
                                                           : {16'd0, dv_quot[15:0]};
    end else begin
      out_data_nxt = (dv_sat || dv_quot[32]) ? 32'hFFFF_FFFF : dv_quot[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTH
  a_clip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r |-> out_data_r == 32'd0)
    else $error("clip_invalid item carries a nonzero depth");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled while the output register is empty");

  a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(lv_level) && $stable(pv_num) && $stable(dv_quot))
    else $error("pipeline moved during a stall");
`endif

endmodule
